@@ sv/pcmg_pkg.sv @@
package pcmg_pkg;

  // Item kinds carried on the mode field
  localparam logic [1:0] MODE_PIXEL = 2'd0;
  localparam logic [1:0] MODE_COEF  = 2'd1;
  localparam logic [1:0] MODE_GAMMA = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MATRIX_EN = 2'd0;
  localparam logic [1:0] CFG_GAMMA_EN  = 2'd1;
  localparam logic [1:0] CFG_SWAP_RB   = 2'd2;

  localparam int CH_W        = 8;
  localparam int NUM_CH      = 3;
  localparam int NUM_COEF    = 9;
  localparam int LUT_ENTRIES = 256;
  localparam int LUT_AW      = $clog2(LUT_ENTRIES);
  localparam int FRAC_BITS   = 32;

  localparam logic [CH_W-1:0] CH_MAX     = 8'd255;
  localparam logic [1:0]      LUT_CH_BAD = 2'd3;
  localparam logic [3:0]      COEF_IDX_LIMIT = 4'd9;

  // Pixel payload in channel order red, green, blue
  typedef struct packed {
    logic [NUM_CH-1:0][CH_W-1:0] ch;
    logic [CH_W-1:0]             byte3;
    logic                        row_end;
  } pix_t;

  // Gamma table write request
  typedef struct packed {
    logic              en;
    logic [1:0]        chan;
    logic [LUT_AW-1:0] idx;
    logic [CH_W-1:0]   val;
  } gw_t;

endpackage

@@ sv/pcmg_mul.sv @@
module pcmg_mul #(
  parameter int COEF_BITS = 41,
  parameter int ACC_W     = 52
) (
  input  logic                                                    clk,
  input  logic                                                    en,
  input  logic [pcmg_pkg::NUM_COEF-1:0][COEF_BITS-1:0]            coef,
  input  logic [pcmg_pkg::NUM_CH-1:0][pcmg_pkg::CH_W-1:0]         ch,
  output logic [pcmg_pkg::NUM_COEF-1:0][ACC_W-1:0]                prod_r
);

  logic [pcmg_pkg::NUM_COEF-1:0][ACC_W-1:0] prod_nxt;

  // Nine products, wrapped to the accumulator width
  always_comb begin
    for (int r = 0; r < pcmg_pkg::NUM_CH; r++) begin
      for (int j = 0; j < pcmg_pkg::NUM_CH; j++) begin
        prod_nxt[r*pcmg_pkg::NUM_CH+j] =
          ACC_W'($signed(coef[r*pcmg_pkg::NUM_CH+j])) * ACC_W'(ch[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

@@ sv/pcmg_sum.sv @@
module pcmg_sum #(
  parameter int ACC_W = 52
) (
  input  logic                                            clk,
  input  logic                                            en,
  input  logic [pcmg_pkg::NUM_COEF-1:0][ACC_W-1:0]        prod,
  output logic [pcmg_pkg::NUM_CH-1:0][pcmg_pkg::CH_W-1:0] res
);

  localparam int HI = pcmg_pkg::FRAC_BITS + pcmg_pkg::CH_W;
  localparam logic [ACC_W-1:0] ROUND = ACC_W'(64'd1 << (pcmg_pkg::FRAC_BITS - 1));

  logic [pcmg_pkg::NUM_CH-1:0][ACC_W-1:0] sum_r;
  logic [pcmg_pkg::NUM_CH-1:0][ACC_W-1:0] sum_nxt;

  // Row sum plus one half
  always_comb begin
    for (int r = 0; r < pcmg_pkg::NUM_CH; r++) begin
      sum_nxt[r] = prod[r*pcmg_pkg::NUM_CH] + prod[r*pcmg_pkg::NUM_CH+1]
                 + prod[r*pcmg_pkg::NUM_CH+2] + ROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

  // Drop the fraction, clamp to 0..255
  always_comb begin
    for (int r = 0; r < pcmg_pkg::NUM_CH; r++) begin
      if (sum_r[r][ACC_W-1]) begin
        res[r] = '0;
      end else if (|sum_r[r][ACC_W-2:HI]) begin
        res[r] = pcmg_pkg::CH_MAX;
      end else begin
        res[r] = sum_r[r][HI-1:pcmg_pkg::FRAC_BITS];
      end
    end
  end

endmodule

@@ sv/pcmg_gamma.sv @@
module pcmg_gamma (
  input  logic                                                   clk,
  input  logic                                                   rd_en,
  input  logic [pcmg_pkg::NUM_CH-1:0][pcmg_pkg::LUT_AW-1:0]      addr,
  input  pcmg_pkg::gw_t                                          gw,
  output logic [pcmg_pkg::NUM_CH-1:0][pcmg_pkg::CH_W-1:0]        rd_r
);

  // One table per channel: one write port, one registered read port each
  for (genvar c = 0; c < pcmg_pkg::NUM_CH; c++) begin : g_tbl
    logic [pcmg_pkg::CH_W-1:0] mem [pcmg_pkg::LUT_ENTRIES];

    always_ff @(posedge clk) begin
      if (gw.en && (gw.chan == 2'(c))) begin
        mem[gw.idx] <= gw.val;
      end
      if (rd_en) begin
        rd_r[c] <= mem[addr[c]];
      end
    end
  end

endmodule

@@ sv/pixel_color_matrix_gamma.sv @@
// Pixel color matrix and gamma: streams 32-bit pixels through a 3x3 matrix in
// S.32 fixed point (rounded, clamped to 0..255) and then a 256-entry gamma
// table per channel. Byte1 is green, byte2/byte0 are red/blue (swapped by the
// swap register), byte3 and the row end marker pass through. One beat is taken
// per clock unless in_stall is high; a pixel passes the input register,
// products, row sums and gamma read on its way out, held only while the
// result side stalls. Coefficient and gamma-entry loads use the same channel
// and give no result beat; they act in stream order, so a pixel sees exactly
// the loads that came before it. Gamma tables hold garbage until written and
// need no clearing pass. Configuration writes are taken at any time with
// cfg_ready held high, but must only be issued while the stream is idle.
module pixel_color_matrix_gamma #(
  parameter int COEF_BITS = 41
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_byte0,
  input  logic [7:0]  in_byte1,
  input  logic [7:0]  in_byte2,
  input  logic [7:0]  in_byte3,
  input  logic        in_row_end_in,
  input  logic [3:0]  in_coef_index,
  input  logic [63:0] in_coef_word,
  input  logic [1:0]  in_lut_channel,
  input  logic [7:0]  in_lut_index,
  input  logic [7:0]  in_lut_value,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte0,
  output logic [7:0]  out_byte1,
  output logic [7:0]  out_byte2,
  output logic [7:0]  out_byte3,
  output logic        out_row_end_out,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_data
);

  // Accumulator wide enough that the sum never wraps, up to the 64-bit limit
  localparam int ACC_W = (COEF_BITS + 11 > 64) ? 64 : COEF_BITS + 11;
  localparam logic [63:0] MAG_MAX = (64'd1 << (COEF_BITS - 1)) - 64'd1;

  localparam int NCH = pcmg_pkg::NUM_CH;
  localparam int CW  = pcmg_pkg::CH_W;

  // Configuration
  logic matrix_en_r, gamma_en_r, swap_r;

  // Coefficient store
  logic [pcmg_pkg::NUM_COEF-1:0][COEF_BITS-1:0] coef_r;
  logic [63:0]          coef_mag;
  logic [63:0]          coef_sat;
  logic [63:0]          coef_full;
  logic [COEF_BITS-1:0] coef_nxt;

  // Pipeline control and payload
  logic           s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  pcmg_pkg::gw_t  s1_gw_r, s2_gw_r, s3_gw_r;
  pcmg_pkg::pix_t s1_pix_r, s2_pix_r, s3_pix_r;
  pcmg_pkg::pix_t pix_nxt;
  pcmg_pkg::gw_t  gw_nxt;
  pcmg_pkg::gw_t  gw_wr;
  logic           adv1, adv2, adv3, adv4;
  logic           in_acc;

  logic [pcmg_pkg::NUM_COEF-1:0][ACC_W-1:0] prod;
  logic [NCH-1:0][CW-1:0] mat_res;
  logic [NCH-1:0][CW-1:0] res_nxt;
  logic [NCH-1:0][CW-1:0] s4_res_r;
  logic [NCH-1:0][CW-1:0] gam_rd;
  logic [NCH-1:0][CW-1:0] fin;
  logic [CW-1:0]          s4_byte3_r;
  logic                   s4_row_end_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_en_r <= 1'b0;
      gamma_en_r  <= 1'b0;
      swap_r      <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pcmg_pkg::CFG_MATRIX_EN: matrix_en_r <= cfg_data;
        pcmg_pkg::CFG_GAMMA_EN:  gamma_en_r  <= cfg_data;
        pcmg_pkg::CFG_SWAP_RB:   swap_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or the next one advances
  assign adv4     = !s4_vld_r || !out_stall;
  assign adv3     = !(s3_vld_r || s3_gw_r.en) || adv4;
  assign adv2     = !(s2_vld_r || s2_gw_r.en) || adv3;
  assign adv1     = !(s1_vld_r || s1_gw_r.en) || adv2;
  assign in_stall = !adv1;
  assign in_acc   = in_valid && adv1;

  // Sign-magnitude to two's complement with magnitude saturation
  always_comb begin
    coef_mag  = {1'b0, in_coef_word[62:0]};
    coef_sat  = (coef_mag > MAG_MAX) ? MAG_MAX : coef_mag;
    coef_full = in_coef_word[63] ? (64'd0 - coef_sat) : coef_sat;
    coef_nxt  = coef_full[COEF_BITS-1:0];
  end

  // Coefficients take effect at acceptance; the pixel ahead multiplies on
  // the same edge, so it still sees the old set.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (in_acc && (in_mode == pcmg_pkg::MODE_COEF) &&
                 (in_coef_index < pcmg_pkg::COEF_IDX_LIMIT)) begin
      coef_r[in_coef_index] <= coef_nxt;
    end
  end

  // Map bytes to red, green, blue
  always_comb begin
    pix_nxt.ch[0]   = swap_r ? in_byte0 : in_byte2;
    pix_nxt.ch[1]   = in_byte1;
    pix_nxt.ch[2]   = swap_r ? in_byte2 : in_byte0;
    pix_nxt.byte3   = in_byte3;
    pix_nxt.row_end = in_row_end_in;
    gw_nxt.en   = in_acc && (in_mode == pcmg_pkg::MODE_GAMMA) &&
                  (in_lut_channel != pcmg_pkg::LUT_CH_BAD);
    gw_nxt.chan = in_lut_channel;
    gw_nxt.idx  = in_lut_index;
    gw_nxt.val  = in_lut_value;
  end

  // Valid bits and gamma write requests travel down the stages; payload
  // holds while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      s3_vld_r   <= 1'b0;
      s4_vld_r   <= 1'b0;
      s1_gw_r.en <= 1'b0;
      s2_gw_r.en <= 1'b0;
      s3_gw_r.en <= 1'b0;
    end else begin
      if (adv1) begin
        s1_vld_r   <= in_acc && (in_mode == pcmg_pkg::MODE_PIXEL);
        s1_gw_r.en <= gw_nxt.en;
      end
      if (adv2) begin
        s2_vld_r   <= s1_vld_r;
        s2_gw_r.en <= s1_gw_r.en;
      end
      if (adv3) begin
        s3_vld_r   <= s2_vld_r;
        s3_gw_r.en <= s2_gw_r.en;
      end
      if (adv4) begin
        s4_vld_r <= s3_vld_r;
      end
    end
    if (adv1) begin
      s1_pix_r     <= pix_nxt;
      s1_gw_r.chan <= gw_nxt.chan;
      s1_gw_r.idx  <= gw_nxt.idx;
      s1_gw_r.val  <= gw_nxt.val;
    end
    if (adv2) begin
      s2_pix_r     <= s1_pix_r;
      s2_gw_r.chan <= s1_gw_r.chan;
      s2_gw_r.idx  <= s1_gw_r.idx;
      s2_gw_r.val  <= s1_gw_r.val;
    end
    if (adv3) begin
      s3_pix_r     <= s2_pix_r;
      s3_gw_r.chan <= s2_gw_r.chan;
      s3_gw_r.idx  <= s2_gw_r.idx;
      s3_gw_r.val  <= s2_gw_r.val;
    end
    if (adv4) begin
      s4_res_r     <= res_nxt;
      s4_byte3_r   <= s3_pix_r.byte3;
      s4_row_end_r <= s3_pix_r.row_end;
    end
  end

  pcmg_mul #(
    .COEF_BITS (COEF_BITS),
    .ACC_W     (ACC_W)
  ) u_mul (
    .clk    (clk),
    .en     (adv2),
    .coef   (coef_r),
    .ch     (s1_pix_r.ch),
    .prod_r (prod)
  );

  pcmg_sum #(
    .ACC_W (ACC_W)
  ) u_sum (
    .clk  (clk),
    .en   (adv3),
    .prod (prod),
    .res  (mat_res)
  );

  // Matrix result or bypass; this also addresses the gamma tables
  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      res_nxt[k] = matrix_en_r ? mat_res[k] : s3_pix_r.ch[k];
    end
  end

  // Gamma writes land in stream order at the same stage that reads
  always_comb begin
    gw_wr    = s3_gw_r;
    gw_wr.en = s3_gw_r.en && adv3;
  end

  pcmg_gamma u_gamma (
    .clk   (clk),
    .rd_en (adv4),
    .addr  (res_nxt),
    .gw    (gw_wr),
    .rd_r  (gam_rd)
  );

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      fin[k] = gamma_en_r ? gam_rd[k] : s4_res_r[k];
    end
  end

  // Back to byte positions
  assign out_valid       = s4_vld_r;
  assign out_byte0       = swap_r ? fin[0] : fin[2];
  assign out_byte1       = fin[1];
  assign out_byte2       = swap_r ? fin[2] : fin[0];
  assign out_byte3       = s4_byte3_r;
  assign out_row_end_out = s4_row_end_r;

endmodule

@@ sv/pcmg_checker.sv @@
module pcmg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte0,
  input logic [7:0] out_byte1,
  input logic [7:0] out_byte2,
  input logic [7:0] out_byte3,
  input logic       out_row_end_out
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present right after reset");

  // Input only stalls when the whole pipe is full behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte0) &&
      $stable(out_byte1) && $stable(out_byte2) && $stable(out_byte3) &&
      $stable(out_row_end_out)))
    else $error("stalled result beat changed or dropped");

endmodule

bind pixel_color_matrix_gamma pcmg_checker u_pcmg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte0       (out_byte0),
  .out_byte1       (out_byte1),
  .out_byte2       (out_byte2),
  .out_byte3       (out_byte3),
  .out_row_end_out (out_row_end_out)
);
